### design/fat12_pkg.sv
// Types and constants shared by the FAT12 table access block.
// Holds the request and response word layouts and the operation codes.
// No dependencies.
package fat12_pkg;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_LOAD  = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [11:0] entry_index;
        logic [11:0] entry_value;
        logic [11:0] byte_address;
        logic [7:0]  byte_value;
    } t_req;

    typedef struct packed {
        logic [11:0] entry_read;
        logic        range_error;
    } t_rsp;

endpackage

### design/fat12_entry_access.sv
// FAT12 allocation table access: byte store with byte load and 12-bit entry read and write.
// Steps: read RD_A, RD_B, DONE; write RD_A, WR_A, WR_B, DONE; load LOAD, DONE;
// rejected or unused DONE. A new word is taken in the strobe cycle, after the
// last request is done. The store has one byte port, one access a cycle.
// Synchronous active-low reset clears the sequencer and strobe; the store is
// left undefined until written.
module fat12_entry_access
    import fat12_pkg::*;
#(
    parameter int TABLE_BYTES = 4096
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    output logic o_strobe,
    output t_rsp o_rsp
);

    localparam int AW = (TABLE_BYTES > 1) ? $clog2(TABLE_BYTES) : 1;
    localparam int XW = 17;
    localparam logic [XW-1:0] LIMIT = XW'(TABLE_BYTES);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD_A = 3'd1;
    localparam logic [2:0] S_RD_B = 3'd2;
    localparam logic [2:0] S_WR_A = 3'd3;
    localparam logic [2:0] S_WR_B = 3'd4;
    localparam logic [2:0] S_LOAD = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0]    r_state, n_state;
    logic          r_strobe;
    t_rsp          r_rsp;
    logic [1:0]    r_op;
    logic          r_odd;
    logic [XW-1:0] r_base;
    logic [11:0]   r_value;
    logic [11:0]   r_baddr;
    logic [7:0]    r_bval;
    logic          r_err;
    logic [7:0]    r_lo;
    logic [7:0]    r_rdata;

    logic [7:0]    mem [0:TABLE_BYTES-1];

    logic          accept;
    logic [XW-1:0] in_base;
    logic          in_err;
    logic          off;
    logic [XW-1:0] addr_sum;
    logic [AW-1:0] mem_addr;
    logic          mem_re;
    logic          mem_we;
    logic [7:0]    mem_wdata;
    logic [11:0]   rd_entry;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);

    // Entry i starts at byte i + i/2.
    assign in_base = XW'(i_req.entry_index) + XW'(i_req.entry_index[11:1]);

    always_comb begin
        unique case (i_req.opcode)
            OP_READ, OP_WRITE: in_err = !((in_base + XW'(1)) < LIMIT);
            OP_LOAD:           in_err = !(XW'(i_req.byte_address) < LIMIT);
            default:           in_err = 1'b0;
        endcase
    end

    // The one address adder: base plus the byte offset that the step needs; a load uses its byte address as is.
    // A write first fetches the byte that is shared with the neighbouring entry.
    always_comb begin
        off       = 1'b0;
        mem_re    = 1'b0;
        mem_we    = 1'b0;
        mem_wdata = r_bval;
        unique case (r_state)
            S_RD_A: begin
                mem_re = 1'b1;
                off    = (r_op == OP_WRITE) ? !r_odd : 1'b0;
            end
            S_RD_B: begin
                mem_re = 1'b1;
                off    = 1'b1;
            end
            S_WR_A: begin
                mem_we    = 1'b1;
                off       = r_odd;
                mem_wdata = r_odd ? r_value[11:4] : r_value[7:0];
            end
            S_WR_B: begin
                mem_we    = 1'b1;
                off       = !r_odd;
                mem_wdata = r_odd ? {r_value[3:0], r_rdata[3:0]}
                                  : {r_rdata[7:4], r_value[11:8]};
            end
            S_LOAD: begin
                mem_we = 1'b1;
            end
            default: begin
                off = 1'b0;
            end
        endcase
    end

    assign addr_sum = (r_state == S_LOAD) ? XW'(r_baddr) : (r_base + XW'(off));
    assign mem_addr = addr_sum[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= mem[mem_addr];
        end
    end

    assign rd_entry = r_odd ? {r_rdata, r_lo[7:4]} : {r_rdata[3:0], r_lo};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (in_err) begin
                        n_state = S_DONE;
                    end else begin
                        unique case (i_req.opcode)
                            OP_READ, OP_WRITE: n_state = S_RD_A;
                            OP_LOAD:           n_state = S_LOAD;
                            default:           n_state = S_DONE;
                        endcase
                    end
                end
            end
            S_RD_A:  n_state = (r_op == OP_WRITE) ? S_WR_A : S_RD_B;
            S_RD_B:  n_state = S_DONE;
            S_WR_A:  n_state = S_WR_B;
            S_WR_B:  n_state = S_DONE;
            S_LOAD:  n_state = S_DONE;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == S_DONE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= i_req.opcode;
            r_odd   <= i_req.entry_index[0];
            r_base  <= in_base;
            r_value <= i_req.entry_value;
            r_baddr <= i_req.byte_address;
            r_bval  <= i_req.byte_value;
            r_err   <= in_err;
        end
        if (r_state == S_RD_B) begin
            r_lo <= r_rdata;
        end
        if (r_state == S_DONE) begin
            r_rsp.range_error <= r_err;
            r_rsp.entry_read  <= (r_op == OP_READ && !r_err) ? rd_entry : 12'd0;
        end
    end

    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

    a_strobe_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state == S_DONE))
        else $error("strobe without a finished request");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("request accepted but block not busy");

    a_zero_unless_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && r_op != OP_READ) |-> (o_rsp.entry_read == 12'd0))
        else $error("entry returned for a non-read request");

    a_no_write_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && busy) |-> !r_err)
        else $error("store written by a rejected request");

endmodule
